FILE: src/pfmu_pkg.sv
// Shared widths, codes and state encoding for the path frontier mate update block.
`timescale 1ns / 1ps

package pfmu_pkg;

  localparam int VERTEX_W = 8;
  localparam int MAX_VERTICES = 2 ** VERTEX_W;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [VERTEX_W-1:0] vertex_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_LOAD = 2'd0;
  localparam kind_t KIND_ARC = 2'd1;
  localparam kind_t KIND_READ = 2'd2;

  localparam status_t STATUS_CONT = 2'd0;
  localparam status_t STATUS_REJECT = 2'd1;
  localparam status_t STATUS_DONE = 2'd2;

  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_SINK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_FILL,
    ST_SCAN,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_JOIN,
    ST_WRITE,
    ST_CLOSE,
    ST_FIN_A,
    ST_FIN_B,
    ST_FIN_C,
    ST_RESP
  } state_t;

endpackage

FILE: src/pfmu_req_if.sv
// Request channel interface carrying one load, arc or read item.
`timescale 1ns / 1ps

interface pfmu_req_if import pfmu_pkg::*; ();
  logic valid;
  logic ready;
  kind_t kind;
  vertex_t vertex_a;
  vertex_t vertex_b;
  logic take;
  logic last_of_a;
  logic last_of_b;
  logic window_start;

  modport source (
    output valid, kind, vertex_a, vertex_b, take, last_of_a, last_of_b, window_start,
    input ready
  );
  modport sink (
    input valid, kind, vertex_a, vertex_b, take, last_of_a, last_of_b, window_start,
    output ready
  );
endinterface

FILE: src/pfmu_rsp_if.sv
// Response channel interface carrying the status, mate value and window top.
`timescale 1ns / 1ps

interface pfmu_rsp_if import pfmu_pkg::*; ();
  logic valid;
  logic ready;
  status_t status;
  vertex_t mate_value;
  vertex_t window_high;

  modport source (
    output valid, status, mate_value, window_high,
    input ready
  );
  modport sink (
    input valid, status, mate_value, window_high,
    output ready
  );
endinterface

FILE: src/path_frontier_mate_update.sv
// Top level of the path frontier mate update block with its mate memory and sequencer.
//
// The req channel takes one request per item: a load writes a mate entry and may restart
// the window, a read returns one mate entry, and an arc request applies one frontier step.
// Every request gives exactly one response on the rsp channel, in order.
// The user sets the source and sink terminals through the APB port while the block is idle;
// the block does not enforce it. All mate entries live in one memory with one write and
// one registered read port. A load goes from acceptance straight to the response state and
// a read passes READ_WAIT first; once a response is registered, the next request is
// accepted in the cycle after. An arc that is not taken runs the final checks FIN_A, FIN_B
// and FIN_C, skipping FIN_C when its lower endpoint fails. A taken arc fetches (FETCH_A,
// FETCH_B, JOIN), writes back (clear both endpoints, then link their mates) and runs the
// final checks. Growing the window writes each new entry whose initial mate lies outside
// the window directly and searches the frontier for each other one, where the frontier
// runs from the lower endpoint to the window top. A closing path replaces write-back and
// final checks by a frontier check; both read one memory entry per cycle via the read port.
// Reset empties the window and restores the terminals to one and two; the memory holds
// undefined data until written. A response waits in its output register while the
// receiver stalls; the next request is accepted meanwhile, and its own response waits
// until that register is free.
`timescale 1ns / 1ps

module path_frontier_mate_update import pfmu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pfmu_req_if.sink           req,
  pfmu_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [1:0] WR_CLR_A = 2'd0;
  localparam logic [1:0] WR_CLR_B = 2'd1;
  localparam logic [1:0] WR_LINK_A = 2'd2;
  localparam logic [1:0] WR_LINK_B = 2'd3;

  function automatic vertex_t init_mate(input vertex_t v, input vertex_t s, input vertex_t k);
    vertex_t m;
    if (v == s) begin
      m = k;
    end else if (v == k) begin
      m = s;
    end else begin
      m = v;
    end
    return m;
  endfunction

  vertex_t mate_mem [MAX_VERTICES];
  vertex_t mem_rdata;
  logic mem_we;
  vertex_t mem_waddr;
  vertex_t mem_wdata;
  logic rd_en;
  vertex_t rd_addr;

  state_t state;
  state_t state_next;

  vertex_t src_vertex;
  vertex_t snk_vertex;
  vertex_t window_top;

  kind_t item_kind;
  vertex_t item_v1;
  vertex_t item_v2;
  logic item_take;
  logic item_l1;
  logic item_l2;

  vertex_t fill_v;
  logic [VERTEX_W:0] scan_x;
  logic pend_vld;
  vertex_t pend_x;
  vertex_t w1;
  vertex_t w2;
  logic [1:0] wr_step;
  status_t res_status;
  vertex_t res_mate;

  logic rsp_valid;
  status_t rsp_status;
  vertex_t rsp_mate;
  vertex_t rsp_high;

  logic req_fire;
  logic rsp_free;
  logic cfg_write;
  vertex_t req_lo;
  vertex_t req_hi;
  logic req_swap;
  vertex_t fill_init;
  logic fill_scan;
  logic fill_last;
  logic scan_hit;
  logic scan_end;
  logic close_bad;
  vertex_t fin_w;
  vertex_t fin_w2;
  logic fin1_bad;
  logic fin2_bad;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SINK) ? {{(PDATA_W-VERTEX_W){1'b0}}, snk_vertex}
                                          : {{(PDATA_W-VERTEX_W){1'b0}}, src_vertex};

  assign req_fire = req.valid && req.ready;
  assign rsp_free = !rsp_valid || rsp.ready;
  assign req_swap = req.vertex_a > req.vertex_b;
  assign req_lo = req_swap ? req.vertex_b : req.vertex_a;
  assign req_hi = req_swap ? req.vertex_a : req.vertex_b;

  assign fill_init = init_mate(fill_v, src_vertex, snk_vertex);
  assign fill_scan = fill_init <= window_top;
  assign fill_last = fill_v == item_v2;
  assign scan_hit = pend_vld && (mem_rdata == fill_v);
  assign scan_end = scan_x > {1'b0, window_top};
  assign close_bad = pend_vld && (pend_x != item_v2) && (mem_rdata != '0)
                     && (mem_rdata != pend_x);
  assign fin_w = (item_v1 <= window_top) ? mem_rdata
                                         : init_mate(item_v1, src_vertex, snk_vertex);
  assign fin_w2 = (item_v2 <= window_top) ? mem_rdata
                                          : init_mate(item_v2, src_vertex, snk_vertex);
  assign fin1_bad = item_l1 && (fin_w != '0) && (fin_w != item_v1);
  assign fin2_bad = item_l2 && (fin_w2 != '0) && (fin_w2 != item_v2);

  assign rsp.valid = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.mate_value = rsp_mate;
  assign rsp.window_high = rsp_high;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mate_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_rdata <= mate_mem[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.kind)
            KIND_LOAD: state_next = ST_RESP;
            KIND_READ: state_next = ST_READ_WAIT;
            KIND_ARC: begin
              if (!req.take) begin
                state_next = ST_FIN_A;
              end else if (req_hi > window_top) begin
                state_next = ST_FILL;
              end else begin
                state_next = ST_FETCH_A;
              end
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_READ_WAIT: state_next = ST_RESP;
      ST_FILL: begin
        if (fill_scan) begin
          state_next = ST_SCAN;
        end else if (fill_last) begin
          state_next = ST_FETCH_A;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = fill_last ? ST_FETCH_A : ST_FILL;
        end
      end
      ST_FETCH_A: state_next = (item_v1 == item_v2) ? ST_RESP : ST_FETCH_B;
      ST_FETCH_B: state_next = ST_JOIN;
      ST_JOIN: begin
        if (w1 == '0 || mem_rdata == '0) begin
          state_next = ST_RESP;
        end else if (w1 == item_v2) begin
          state_next = ST_CLOSE;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (wr_step == WR_LINK_B) begin
          state_next = ST_FIN_A;
        end
      end
      ST_CLOSE: begin
        if (close_bad || scan_end) begin
          state_next = ST_RESP;
        end
      end
      ST_FIN_A: state_next = ST_FIN_B;
      ST_FIN_B: state_next = fin1_bad ? ST_RESP : ST_FIN_C;
      ST_FIN_C: state_next = ST_RESP;
      ST_RESP: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    mem_we = 1'b0;
    mem_waddr = fill_v;
    mem_wdata = fill_init;
    rd_en = 1'b0;
    rd_addr = item_v1;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req_fire && req.kind == KIND_LOAD) begin
          mem_we = 1'b1;
          mem_waddr = req.vertex_a;
          mem_wdata = req.vertex_b;
        end
        if (req_fire && req.kind == KIND_READ) begin
          rd_en = 1'b1;
          rd_addr = req.vertex_a;
        end
      end
      ST_FILL: begin
        mem_we = !fill_scan;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          mem_we = 1'b1;
          mem_wdata = pend_x;
        end else if (scan_end) begin
          mem_we = 1'b1;
        end else begin
          rd_en = 1'b1;
          rd_addr = scan_x[VERTEX_W-1:0];
        end
      end
      ST_FETCH_A, ST_FIN_A: begin
        rd_en = 1'b1;
      end
      ST_FETCH_B, ST_FIN_B: begin
        rd_en = 1'b1;
        rd_addr = item_v2;
      end
      ST_WRITE: begin
        case (wr_step)
          WR_CLR_A: begin
            mem_we = w1 != item_v1;
            mem_waddr = item_v1;
            mem_wdata = '0;
          end
          WR_CLR_B: begin
            mem_we = w2 != item_v2;
            mem_waddr = item_v2;
            mem_wdata = '0;
          end
          WR_LINK_A: begin
            mem_we = w1 <= window_top;
            mem_waddr = w1;
            mem_wdata = w2;
          end
          default: begin
            mem_we = w2 <= window_top;
            mem_waddr = w2;
            mem_wdata = w1;
          end
        endcase
      end
      ST_CLOSE: begin
        if (!close_bad && !scan_end) begin
          rd_en = 1'b1;
          rd_addr = scan_x[VERTEX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      src_vertex <= vertex_t'(1);
      snk_vertex <= vertex_t'(2);
      window_top <= '0;
      pend_vld <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        if (paddr[2] == REG_SINK) begin
          snk_vertex <= pwdata[VERTEX_W-1:0];
        end else begin
          src_vertex <= pwdata[VERTEX_W-1:0];
        end
      end

      if (state == ST_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
        rsp_status <= res_status;
        rsp_mate <= res_mate;
        rsp_high <= window_top;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            item_kind <= req.kind;
            item_v1 <= req_lo;
            item_v2 <= req_hi;
            item_take <= req.take;
            item_l1 <= req_swap ? req.last_of_b : req.last_of_a;
            item_l2 <= req_swap ? req.last_of_a : req.last_of_b;
            fill_v <= window_top + vertex_t'(1);
            res_status <= STATUS_CONT;
            res_mate <= '0;
            if (req.kind == KIND_LOAD) begin
              if (req.window_start || req.vertex_a > window_top) begin
                window_top <= req.vertex_a;
              end
            end
          end
        end
        ST_READ_WAIT: begin
          res_mate <= mem_rdata;
        end
        ST_FILL: begin
          if (fill_scan) begin
            scan_x <= {1'b0, item_v1};
            pend_vld <= 1'b0;
          end else if (fill_last) begin
            window_top <= item_v2;
          end else begin
            fill_v <= fill_v + vertex_t'(1);
          end
        end
        ST_SCAN: begin
          if (scan_hit || scan_end) begin
            pend_vld <= 1'b0;
            if (fill_last) begin
              window_top <= item_v2;
            end else begin
              fill_v <= fill_v + vertex_t'(1);
            end
          end else begin
            pend_vld <= 1'b1;
            pend_x <= scan_x[VERTEX_W-1:0];
            scan_x <= scan_x + 1'b1;
          end
        end
        ST_FETCH_A: begin
          if (item_v1 == item_v2) begin
            res_status <= STATUS_REJECT;
          end
        end
        ST_FETCH_B: begin
          w1 <= mem_rdata;
        end
        ST_JOIN: begin
          w2 <= mem_rdata;
          wr_step <= WR_CLR_A;
          scan_x <= {1'b0, item_v1} + 1'b1;
          pend_vld <= 1'b0;
          if (w1 == '0 || mem_rdata == '0) begin
            res_status <= STATUS_REJECT;
          end
        end
        ST_WRITE: begin
          wr_step <= wr_step + 1'b1;
        end
        ST_CLOSE: begin
          if (close_bad) begin
            res_status <= STATUS_REJECT;
            pend_vld <= 1'b0;
          end else if (scan_end) begin
            res_status <= STATUS_DONE;
            pend_vld <= 1'b0;
          end else begin
            pend_vld <= 1'b1;
            pend_x <= scan_x[VERTEX_W-1:0];
            scan_x <= scan_x + 1'b1;
          end
        end
        ST_FIN_B: begin
          if (fin1_bad) begin
            res_status <= STATUS_REJECT;
          end
        end
        ST_FIN_C: begin
          if (fin2_bad) begin
            res_status <= STATUS_REJECT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A read and a write of the same entry in one cycle would return stale data.
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && rd_en) |-> (mem_waddr != rd_addr))
    else $error("mate memory read and write collide on one entry");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_SCAN) |-> (fill_v > window_top && fill_v <= item_v2))
    else $error("fill vertex left the range being added to the window");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && item_kind == KIND_ARC && item_take) |-> (item_v1 <= item_v2))
    else $error("arc endpoints are not ordered");

  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_RESP))
    else $error("response raised outside the response state");

  assert property (@(posedge clk) disable iff (rst)
    !$stable(window_top) |->
      $past(state == ST_IDLE || state == ST_FILL || state == ST_SCAN))
    else $error("window top changed outside a load or a fill");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for path_frontier_mate_update with random handshakes and APB setup.
`timescale 1ns / 1ps

module tb;
  import pfmu_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASE_ITEMS = 215;
  localparam int TAIL_CYCLES = 20;
  localparam kind_t KIND_NONE = 2'd3;

  typedef struct packed {
    kind_t   kind;
    vertex_t vertex_a;
    vertex_t vertex_b;
    logic    take;
    logic    last_of_a;
    logic    last_of_b;
    logic    window_start;
  } req_item_t;

  typedef struct packed {
    status_t status;
    vertex_t mate_value;
    vertex_t window_high;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               req_valid = 1'b0;
  req_item_t          req_bits = '0;
  logic               rsp_rdy = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pfmu_req_if req_ch ();
  pfmu_rsp_if rsp_ch ();

  assign req_ch.valid = req_valid;
  assign req_ch.kind = req_bits.kind;
  assign req_ch.vertex_a = req_bits.vertex_a;
  assign req_ch.vertex_b = req_bits.vertex_b;
  assign req_ch.take = req_bits.take;
  assign req_ch.last_of_a = req_bits.last_of_a;
  assign req_ch.last_of_b = req_bits.last_of_b;
  assign req_ch.window_start = req_bits.window_start;
  assign rsp_ch.ready = rsp_rdy;

  path_frontier_mate_update dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the mate memory, window and terminals.
  vertex_t mate_model [MAX_VERTICES] = '{default: '0};
  int      win_lo = 1;
  int      win_top = 0;
  vertex_t src_cfg = 8'd1;
  vertex_t snk_cfg = 8'd2;

  rsp_item_t pending_rsp [$];
  bit        quiet = 1'b0;
  int        stall_left = 0;
  int        bad_rsp = 0;
  int        cycle_count = 0;
  int        sent_items = 0;
  int        read_count = 0;
  int        done_count = 0;
  int        reject_count = 0;
  int        pair_count = 0;

  function automatic int first_mate(int v);
    if (v == src_cfg) return snk_cfg;
    if (v == snk_cfg) return src_cfg;
    return v;
  endfunction

  function automatic bit open_at(int v, int vmax);
    int w;
    w = (v <= vmax) ? int'(mate_model[v]) : first_mate(v);
    return w != 0 && w != v;
  endfunction

  function automatic status_t arc_step(int v1, int v2, bit tk, bit l1, bit l2);
    int vmax, w, w1, w2, v, x;
    win_lo = v1;
    vmax = win_top;
    if (tk) begin
      if (vmax < v2) begin
        for (v = vmax + 1; v <= v2; v++) begin
          w = first_mate(v);
          if (w <= vmax) begin
            for (x = v1; x <= vmax; x++) begin
              if (mate_model[x] == v) begin
                w = x;
                break;
              end
            end
          end
          mate_model[v] = vertex_t'(w);
        end
        vmax = v2;
        win_top = v2;
      end
      if (v1 == v2) return STATUS_REJECT;
      w1 = mate_model[v1];
      w2 = mate_model[v2];
      if (w1 == 0 || w2 == 0) return STATUS_REJECT;
      if (w1 == v2) begin
        for (v = v1 + 1; v <= vmax; v++) begin
          if (v != v2 && mate_model[v] != 0 && mate_model[v] != v) return STATUS_REJECT;
        end
        return STATUS_DONE;
      end
      if (w1 != v1) mate_model[v1] = '0;
      if (w2 != v2) mate_model[v2] = '0;
      if (w1 <= vmax) mate_model[w1] = vertex_t'(w2);
      if (w2 <= vmax) mate_model[w2] = vertex_t'(w1);
    end
    if (l1 && open_at(v1, vmax)) return STATUS_REJECT;
    if (l2 && open_at(v2, vmax)) return STATUS_REJECT;
    return STATUS_CONT;
  endfunction

  function automatic rsp_item_t frontier_step(req_item_t it);
    rsp_item_t r;
    int a, b;
    a = it.vertex_a;
    b = it.vertex_b;
    r.status = STATUS_CONT;
    r.mate_value = '0;
    case (it.kind)
      KIND_LOAD: begin
        mate_model[a] = it.vertex_b;
        if (it.window_start) begin
          win_lo = a;
          win_top = a;
        end else if (a > win_top) begin
          win_top = a;
        end
      end
      KIND_ARC: begin
        if (a <= b) r.status = arc_step(a, b, it.take, it.last_of_a, it.last_of_b);
        else r.status = arc_step(b, a, it.take, it.last_of_b, it.last_of_a);
      end
      KIND_READ: r.mate_value = mate_model[a];
      default: ;
    endcase
    r.window_high = vertex_t'(win_top);
    return r;
  endfunction

  // Vertex zero is never loaded, so an arc ending there must not look at its entry.
  function automatic req_item_t avoid_vertex_zero(req_item_t it);
    req_item_t r;
    r = it;
    if (r.kind == KIND_ARC && r.vertex_b == 0) begin
      r.take = 1'b0;
      r.last_of_b = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_item_t want;
    int stall;
    if (!rst) begin
      if (rsp_ch.valid && rsp_rdy) begin
        if (pending_rsp.size() == 0) begin
          if (bad_rsp < 10)
            $display("unexpected response: status %0d mate %0d window %0d",
                     rsp_ch.status, rsp_ch.mate_value, rsp_ch.window_high);
          bad_rsp++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.mate_value !== want.mate_value ||
              rsp_ch.window_high !== want.window_high) begin
            if (bad_rsp < 10)
              $display("mismatch: status %0d/%0d mate %0d/%0d window %0d/%0d (exp/act)",
                       want.status, rsp_ch.status, want.mate_value, rsp_ch.mate_value,
                       want.window_high, rsp_ch.window_high);
            bad_rsp++;
          end
        end
        stall = quiet ? 0 : $urandom_range(0, 9);
        if (stall != 0) begin
          rsp_rdy <= 1'b0;
          stall_left = stall;
        end
      end else if (!rsp_rdy) begin
        stall_left--;
        if (stall_left == 0) rsp_rdy <= 1'b1;
      end
    end
  end

  task automatic issue_request(input req_item_t it, output status_t st);
    int gap;
    rsp_item_t want;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bits <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    want = frontier_step(it);
    pending_rsp.push_back(want);
    st = want.status;
    if (it.kind != KIND_NONE) sent_items++;
    if (it.kind == KIND_READ) read_count++;
    if (want.status == STATUS_DONE) done_count++;
    if (want.status == STATUS_REJECT) reject_count++;
  endtask

  task automatic drive_item(input kind_t k, input int a, input int b, input logic tk,
                            input logic la, input logic lb, input logic ws);
    status_t st;
    issue_request('{k, vertex_t'(a), vertex_t'(b), tk, la, lb, ws}, st);
  endtask

  task automatic settle_outputs();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic write_terminal(input logic idx, input vertex_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SOURCE) src_cfg = val;
    else snk_cfg = val;
    @(posedge clk);
  endtask

  task automatic check_terminal(input logic idx, input vertex_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(val)) begin
      if (bad_rsp < 10)
        $display("register %0d read back %0d, expected %0d", idx, prdata, val);
      bad_rsp++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_register_reset();
    check_terminal(REG_SOURCE, 8'd1);
    check_terminal(REG_SINK, 8'd2);
  endtask

  // Hand-picked requests under the reset terminals one and two.
  task automatic test_directed();
    drive_item(KIND_ARC, 1, 255, 1, 0, 0, 0);
    drive_item(KIND_READ, 1, 0, 0, 0, 0, 0);
    drive_item(KIND_READ, 255, 0, 0, 0, 0, 0);
    drive_item(KIND_LOAD, 1, 2, 0, 0, 0, 1);
    drive_item(KIND_ARC, 1, 2, 1, 1, 1, 0);
    drive_item(KIND_LOAD, 1, 2, 1, 1, 1, 1);
    drive_item(KIND_ARC, 1, 3, 1, 0, 0, 0);
    drive_item(KIND_ARC, 4, 3, 1, 0, 1, 0);
    drive_item(KIND_READ, 2, 0, 0, 0, 0, 0);
    drive_item(KIND_ARC, 2, 4, 1, 0, 0, 0);
    drive_item(KIND_ARC, 3, 3, 1, 0, 0, 0);
    drive_item(KIND_ARC, 1, 4, 1, 0, 0, 0);
    drive_item(KIND_ARC, 2, 5, 0, 1, 0, 0);
    drive_item(KIND_NONE, 255, 255, 1, 1, 1, 1);
    drive_item(KIND_NONE, 1, 0, 0, 0, 0, 0);
    drive_item(KIND_ARC, 7, 0, 0, 1, 0, 1);
    drive_item(KIND_LOAD, 255, 255, 0, 0, 0, 0);
    drive_item(KIND_READ, 255, 0, 1, 1, 1, 1);
    drive_item(KIND_LOAD, 128, 0, 0, 0, 0, 1);
    drive_item(KIND_READ, 128, 0, 0, 0, 0, 0);
    drive_item(KIND_ARC, 255, 255, 0, 1, 1, 0);
    drive_item(KIND_READ, 4, 0, 0, 0, 0, 0);
  endtask

  // One frontier walk over a small graph on consecutive vertices near the terminals.
  task automatic run_path_sequence();
    int n, lo, hi, lo_t, hi_t, i, j, k, m;
    int ea [$];
    int eb [$];
    logic la, lb, tk;
    req_item_t it;
    status_t st;
    n = $urandom_range(3, 8);
    lo_t = (src_cfg < snk_cfg) ? src_cfg : snk_cfg;
    hi_t = (src_cfg < snk_cfg) ? snk_cfg : src_cfg;
    if (hi_t - lo_t < n) lo = lo_t - $urandom_range(0, n - 1 - (hi_t - lo_t));
    else if ($urandom_range(0, 1) != 0) lo = lo_t - $urandom_range(0, n - 1);
    else lo = hi_t - $urandom_range(0, n - 1);
    if (lo < 1) lo = 1;
    if (lo + n - 1 > 255) lo = 256 - n;
    hi = lo + n - 1;
    for (i = lo; i < hi; i++) begin
      for (j = i + 1; j <= hi && j <= i + 3; j++) begin
        if (j == i + 1 || $urandom_range(0, 1) != 0) begin
          ea.push_back(i);
          eb.push_back(j);
        end
      end
    end
    it = req_item_t'($urandom);
    drive_item(KIND_LOAD, lo, first_mate(lo), it.take, it.last_of_a, it.last_of_b, 1'b1);
    for (k = 0; k < ea.size(); k++) begin
      la = 1'b1;
      lb = 1'b1;
      for (m = k + 1; m < ea.size(); m++) begin
        if (ea[m] == ea[k] || eb[m] == ea[k]) la = 1'b0;
        if (ea[m] == eb[k] || eb[m] == eb[k]) lb = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0) la = ~la;
        else lb = ~lb;
      end
      tk = ($urandom_range(0, 9) < 6);
      it = req_item_t'($urandom);
      it.kind = KIND_ARC;
      it.take = tk;
      if ($urandom_range(0, 3) == 0) begin
        it.vertex_a = vertex_t'(eb[k]);
        it.vertex_b = vertex_t'(ea[k]);
        it.last_of_a = lb;
        it.last_of_b = la;
      end else begin
        it.vertex_a = vertex_t'(ea[k]);
        it.vertex_b = vertex_t'(eb[k]);
        it.last_of_a = la;
        it.last_of_b = lb;
      end
      issue_request(it, st);
      if ($urandom_range(0, 7) == 0) drive_item(KIND_READ, $urandom_range(lo, hi), 0, 0, 0, 0, 0);
      if (st != STATUS_CONT) break;
    end
  endtask

  task automatic send_noise();
    req_item_t it;
    status_t st;
    int b;
    it = req_item_t'($urandom);
    it.vertex_a = vertex_t'($urandom_range(1, 255));
    case ($urandom_range(0, 9))
      0, 1: begin
        it.kind = KIND_LOAD;
        it.window_start = ($urandom_range(0, 3) == 0);
      end
      2, 3: it.kind = KIND_READ;
      4: it.kind = KIND_NONE;
      default: begin
        it.kind = KIND_ARC;
        if ($urandom_range(0, 9) < 7) begin
          b = int'(it.vertex_a) + $urandom_range(0, 8) - 4;
          if (b < 0) b = 0;
          if (b > 255) b = 255;
          it.vertex_b = vertex_t'(b);
        end
        it = avoid_vertex_zero(it);
      end
    endcase
    issue_request(it, st);
  endtask

  task automatic test_terminal_pairs();
    int p, goal;
    vertex_t s, t;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin s = 8'd255; t = 8'd254; end
        1: begin s = 8'd1; t = 8'd255; end
        2: begin s = 8'd254; t = 8'd1; end
        5: begin s = 8'd1; t = 8'd2; end
        default: begin
          s = vertex_t'($urandom_range(1, 255));
          t = vertex_t'($urandom_range(1, 255));
        end
      endcase
      // The block must be idle before its terminals change.
      settle_outputs();
      write_terminal(REG_SOURCE, s);
      write_terminal(REG_SINK, t);
      check_terminal(REG_SOURCE, s);
      check_terminal(REG_SINK, t);
      pair_count++;
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0) run_path_sequence();
        else send_noise();
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed();
    test_terminal_pairs();
    settle_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests over %0d terminal settings, %0d of them reads.",
             sent_items, pair_count, read_count);
    $display("Predicted %0d completed paths and %0d rejections.", done_count, reject_count);
    if (bad_rsp == 0 && pending_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
